// ===== rtl/core/psl_pkg.sv =====
// Shared types and constants for the periodic sample logger.
// Holds the record descriptor passed from front to back and the serial memory codes.
// No dependencies.
`default_nettype none

package psl_pkg;

  localparam int unsigned IdxBits = 15;
  localparam int unsigned FrameAddrBits = 24;
  localparam int unsigned ScaledBits = 16;
  localparam int unsigned RawBits = 12;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_CLOCK_HOUR = 3'd0;
  localparam logic [2:0] REG_CLOCK_MINUTE = 3'd1;
  localparam logic [2:0] REG_START_HOUR = 3'd2;
  localparam logic [2:0] REG_START_MINUTE = 3'd3;
  localparam logic [2:0] REG_INTERVAL = 3'd4;
  localparam logic [2:0] REG_LIMIT = 3'd5;

  // Serial memory opcodes.
  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_WRITE = 8'h02;

  // Byte positions within one logged record.
  localparam logic [3:0] BYTE_WREN = 4'd0;
  localparam logic [3:0] BYTE_OPCODE = 4'd1;
  localparam logic [3:0] BYTE_ADDR_HI = 4'd2;
  localparam logic [3:0] BYTE_ADDR_MID = 4'd3;
  localparam logic [3:0] BYTE_ADDR_LO = 4'd4;
  localparam logic [3:0] BYTE_HOUR = 4'd5;
  localparam logic [3:0] BYTE_MINUTE = 4'd6;
  localparam logic [3:0] BYTE_SECOND = 4'd7;
  localparam logic [3:0] BYTE_A_HI = 4'd8;
  localparam logic [3:0] BYTE_A_LO = 4'd9;
  localparam logic [3:0] BYTE_B_HI = 4'd10;
  localparam logic [3:0] BYTE_B_LO = 4'd11;

  localparam logic [5:0] SecWrap = 6'd60;
  localparam logic [5:0] MinWrap = 6'd60;
  localparam logic [4:0] HourWrap = 5'd24;
  localparam logic [6:0] IcountMax = 7'd100;
  localparam int unsigned RecStride = 7;

  // floor(s * 51 / 5) equals (s * ScaleMul) >> ScaleShift for every 12-bit s.
  localparam logic [23:0] ScaleMul = 24'd10695476;
  localparam int unsigned ScaleShift = 20;

  typedef struct packed {
    logic [IdxBits-1:0]       idx;
    logic [FrameAddrBits-1:0] addr;
    logic [4:0]               hour;
    logic [5:0]               minute;
    logic [5:0]               second;
    logic [ScaledBits-1:0]    scaled_a;
    logic [ScaledBits-1:0]    scaled_b;
  } record_t;

endpackage

`default_nettype wire

// ===== rtl/core/psl_front.sv =====
// Front part of the sample logger: configuration registers, time of day and record decision.
// Depends on psl_pkg; feeds record descriptors into psl_queue.
`default_nettype none

module psl_front #(
  parameter int unsigned ADDR_BITS = 24,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [11:0]           channel_a_sample_i,
  input  wire logic [11:0]           channel_b_sample_i,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [4:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       rec_valid_o,
  output psl_pkg::record_t           rec_o
);
  import psl_pkg::*;

  logic [4:0]  clock_set_hour_q, clock_set_hour_d;
  logic [5:0]  clock_set_minute_q, clock_set_minute_d;
  logic [4:0]  start_hour_q, start_hour_d;
  logic [5:0]  start_minute_q, start_minute_d;
  logic [6:0]  interval_q, interval_d;
  logic [14:0] limit_q, limit_d;

  logic [5:0]  second_q, second_d;
  logic [5:0]  minute_q, minute_d;
  logic [4:0]  hour_q, hour_d;
  logic [6:0]  icount_q, icount_d;
  logic        acquiring_q, acquiring_d;
  logic [14:0] done_q, done_d;
  logic [ADDR_BITS-1:0] waddr_q, waddr_d;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [5:0]  sec_inc, min_inc, sec_new, min_new;
  logic [4:0]  hour_inc, hour_new;
  logic [6:0]  icount_new;
  logic        acq_new, do_log;
  logic [RawBits-1:0] raw_a, raw_b;
  logic [RawBits+23:0] prod_a, prod_b;

  assign cfg_wr = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  assign raw_a = RawBits'(channel_a_sample_i[SAMPLE_BITS-1:0]);
  assign raw_b = RawBits'(channel_b_sample_i[SAMPLE_BITS-1:0]);
  assign prod_a = raw_a * ScaleMul;
  assign prod_b = raw_b * ScaleMul;

  always_comb begin
    sec_inc = second_q + 6'd1;
    min_inc = minute_q + 6'd1;
    hour_inc = hour_q + 5'd1;
    sec_new = sec_inc;
    min_new = minute_q;
    hour_new = hour_q;
    if (sec_inc >= SecWrap) begin
      sec_new = '0;
      min_new = min_inc;
    end
    if (min_new >= MinWrap) begin
      min_new = '0;
      hour_new = hour_inc;
    end
    if (hour_new >= HourWrap) begin
      hour_new = '0;
    end
    icount_new = (icount_q < IcountMax) ? icount_q + 7'd1 : icount_q;
    acq_new = acquiring_q | ((min_new == start_minute_q) && (hour_new == start_hour_q));
    do_log = acq_new && (icount_new >= interval_q) && (done_q < limit_q);
  end

  always_comb begin
    clock_set_hour_d = clock_set_hour_q;
    clock_set_minute_d = clock_set_minute_q;
    start_hour_d = start_hour_q;
    start_minute_d = start_minute_q;
    interval_d = interval_q;
    limit_d = limit_q;
    second_d = second_q;
    minute_d = minute_q;
    hour_d = hour_q;
    icount_d = icount_q;
    acquiring_d = acquiring_q;
    done_d = done_q;
    waddr_d = waddr_q;
    if (accept_i) begin
      second_d = sec_new;
      minute_d = min_new;
      hour_d = hour_new;
      icount_d = do_log ? '0 : icount_new;
      acquiring_d = acq_new;
      if (do_log) begin
        done_d = done_q + 15'd1;
        waddr_d = waddr_q + ADDR_BITS'(RecStride);
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CLOCK_HOUR: begin
          if (pwdata[4:0] < HourWrap) begin
            clock_set_hour_d = pwdata[4:0];
            hour_d = pwdata[4:0];
            second_d = '0;
          end
        end
        REG_CLOCK_MINUTE: begin
          if (pwdata[5:0] < MinWrap) begin
            clock_set_minute_d = pwdata[5:0];
            minute_d = pwdata[5:0];
            second_d = '0;
          end
        end
        REG_START_HOUR: start_hour_d = pwdata[4:0];
        REG_START_MINUTE: start_minute_d = pwdata[5:0];
        REG_INTERVAL: interval_d = pwdata[6:0];
        REG_LIMIT: limit_d = pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_set_hour_q <= '0;
      clock_set_minute_q <= '0;
      start_hour_q <= '0;
      start_minute_q <= '0;
      interval_q <= '0;
      limit_q <= '0;
      second_q <= '0;
      minute_q <= '0;
      hour_q <= '0;
      icount_q <= '0;
      acquiring_q <= 1'b0;
      done_q <= '0;
      waddr_q <= '0;
    end else begin
      clock_set_hour_q <= clock_set_hour_d;
      clock_set_minute_q <= clock_set_minute_d;
      start_hour_q <= start_hour_d;
      start_minute_q <= start_minute_d;
      interval_q <= interval_d;
      limit_q <= limit_d;
      second_q <= second_d;
      minute_q <= minute_d;
      hour_q <= hour_d;
      icount_q <= icount_d;
      acquiring_q <= acquiring_d;
      done_q <= done_d;
      waddr_q <= waddr_d;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CLOCK_HOUR: prdata = 32'(clock_set_hour_q);
      REG_CLOCK_MINUTE: prdata = 32'(clock_set_minute_q);
      REG_START_HOUR: prdata = 32'(start_hour_q);
      REG_START_MINUTE: prdata = 32'(start_minute_q);
      REG_INTERVAL: prdata = 32'(interval_q);
      REG_LIMIT: prdata = 32'(limit_q);
      default: prdata = '0;
    endcase
  end

  assign rec_valid_o = accept_i & do_log;

  always_comb begin
    rec_o.idx = done_q;
    rec_o.addr = FrameAddrBits'(waddr_q);
    rec_o.hour = hour_new;
    rec_o.minute = min_new;
    rec_o.second = sec_new;
    rec_o.scaled_a = prod_a[ScaleShift +: ScaledBits];
    rec_o.scaled_b = prod_b[ScaleShift +: ScaledBits];
  end

endmodule

`default_nettype wire

// ===== rtl/core/psl_queue.sv =====
// Two-entry queue of record descriptors between the front and back parts.
// Depends on psl_pkg.
`default_nettype none

module psl_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire psl_pkg::record_t  wr_rec_i,
  input  wire logic              rd_i,
  output logic                   full_o,
  output logic                   empty_o,
  output psl_pkg::record_t       rd_rec_o
);
  import psl_pkg::*;

  record_t    entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_wr, do_rd;

  assign full_o = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_wr = wr_i & ~full_o;
  assign do_rd = rd_i & ~empty_o;
  assign rd_rec_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    count_d = count_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_rec_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/psl_back.sv =====
// Back part of the sample logger: turns one record descriptor into twelve serial memory bytes.
// Depends on psl_pkg; reads descriptors from psl_queue and drives the result register.
`default_nettype none

module psl_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire psl_pkg::record_t  q_rec_i,
  output logic                   q_rd_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic [7:0]             out_byte_o,
  output logic                   frame_end_o,
  output logic                   run_last_o,
  output logic [14:0]            record_index_o
);
  import psl_pkg::*;

  logic        busy_q, busy_d;
  logic [3:0]  pos_q, pos_d;
  record_t     rec_q;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  obyte_q;
  logic        oend_q, olast_q;
  logic [14:0] oidx_q;
  logic        advance, last_pos, fetch;
  logic [7:0]  sel_byte;

  assign advance = busy_q & (~ovalid_q | pop_i);
  assign last_pos = (pos_q == BYTE_B_LO);
  assign fetch = ~q_empty_i & (~busy_q | (advance & last_pos));
  assign q_rd_o = fetch;

  always_comb begin
    case (pos_q)
      BYTE_WREN: sel_byte = OP_WREN;
      BYTE_OPCODE: sel_byte = OP_WRITE;
      BYTE_ADDR_HI: sel_byte = rec_q.addr[23:16];
      BYTE_ADDR_MID: sel_byte = rec_q.addr[15:8];
      BYTE_ADDR_LO: sel_byte = rec_q.addr[7:0];
      BYTE_HOUR: sel_byte = 8'(rec_q.hour);
      BYTE_MINUTE: sel_byte = 8'(rec_q.minute);
      BYTE_SECOND: sel_byte = 8'(rec_q.second);
      BYTE_A_HI: sel_byte = rec_q.scaled_a[15:8];
      BYTE_A_LO: sel_byte = rec_q.scaled_a[7:0];
      BYTE_B_HI: sel_byte = rec_q.scaled_b[15:8];
      BYTE_B_LO: sel_byte = rec_q.scaled_b[7:0];
      default: sel_byte = '0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pos_d = pos_q;
    if (advance) begin
      pos_d = pos_q + 4'd1;
      if (last_pos) begin
        busy_d = 1'b0;
      end
    end
    if (fetch) begin
      busy_d = 1'b1;
      pos_d = BYTE_WREN;
    end
    ovalid_d = ovalid_q;
    if (advance) begin
      ovalid_d = 1'b1;
    end else if (pop_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q <= BYTE_WREN;
      ovalid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q <= pos_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      rec_q <= q_rec_i;
    end
    if (advance) begin
      obyte_q <= sel_byte;
      oend_q <= (pos_q == BYTE_WREN) | last_pos;
      olast_q <= last_pos;
      oidx_q <= rec_q.idx;
    end
  end

  assign empty_o = ~ovalid_q;
  assign out_byte_o = obyte_q;
  assign frame_end_o = oend_q;
  assign run_last_o = olast_q;
  assign record_index_o = oidx_q;

endmodule

`default_nettype wire

// ===== rtl/core/periodic_sample_logger.sv =====
// Periodic sample logger, top level. An accepted logging tick passes through the record queue,
// the back end's record register and its output byte register; its twelve bytes then leave at
// one per cycle while pop is held, and the back end sets the record rate. Every tick, logging
// or not, is taken only while the two-entry record queue is not full, so ticks go on meanwhile.
// Reset is asynchronous and active low; it clears the clock, counters, registers and queue.
// Depends on psl_pkg, psl_front, psl_queue and psl_back.
`default_nettype none

module periodic_sample_logger #(
  parameter int unsigned ADDR_BITS = 24,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [11:0] channel_a_sample_i,
  input  wire logic [11:0] channel_b_sample_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [7:0]       out_byte_o,
  output logic             frame_end_o,
  output logic             run_last_o,
  output logic [14:0]      record_index_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import psl_pkg::*;

  logic    accept;
  logic    rec_valid;
  record_t rec_in, rec_out;
  logic    q_empty, q_rd;

  assign pready = 1'b1;
  assign accept = push_i & ~full_o;

  psl_front #(
    .ADDR_BITS  (ADDR_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .channel_a_sample_i(channel_a_sample_i),
    .channel_b_sample_i(channel_b_sample_i),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .rec_valid_o       (rec_valid),
    .rec_o             (rec_in)
  );

  psl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (rec_valid),
    .wr_rec_i(rec_in),
    .rd_i    (q_rd),
    .full_o  (full_o),
    .empty_o (q_empty),
    .rd_rec_o(rec_out)
  );

  psl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_rec_i       (rec_out),
    .q_rd_o        (q_rd),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .out_byte_o    (out_byte_o),
    .frame_end_o   (frame_end_o),
    .run_last_o    (run_last_o),
    .record_index_o(record_index_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/psl_checker.sv =====
// Port-level checker for the periodic sample logger, bound to the top level.
// Depends on psl_pkg and the top-level ports.
`default_nettype none

module psl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty_o,
  input wire logic        pop_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        frame_end_o,
  input wire logic        run_last_o,
  input wire logic [14:0] record_index_o
);
  import psl_pkg::*;

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && run_last_o) |-> frame_end_o)
    else $error("last byte of a record does not end a frame");

  a_mid_frame_end_is_wren: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && frame_end_o && !run_last_o) |-> (out_byte_o == OP_WREN))
    else $error("frame ends early on a byte that is not write enable");

  a_index_steady_in_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((!empty_o && pop_i && !run_last_o) ##1 !empty_o) |->
      (record_index_o == $past(record_index_o)))
    else $error("record index changes within a record");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_byte_o)))
    else $error("waiting byte changed or vanished while not popped");

endmodule

bind periodic_sample_logger psl_checker u_psl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty_o       (empty_o),
  .pop_i         (pop_i),
  .out_byte_o    (out_byte_o),
  .frame_end_o   (frame_end_o),
  .run_last_o    (run_last_o),
  .record_index_o(record_index_o)
);

`default_nettype wire
